@@ design/ifmt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ifmt_pkg
// Shared types and constants for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package ifmt_pkg;

    typedef enum logic [1:0] {
        KIND_SDEC = 2'd0,
        KIND_UDEC = 2'd1,
        KIND_HEX  = 2'd2,
        KIND_OCT  = 2'd3
    } t_kind;

    localparam int MAX_DIGITS = 11;
    localparam int DIG_IW     = $clog2(MAX_DIGITS);

    // Reciprocal of ten in 0.35 fixed point; exact for every 32-bit dividend.
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOWA  = 8'h61;

    typedef struct packed {
        logic load;
        logic mul;
        logic dig;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic dig_done;
        logic out_free;
        logic last;
    } t_sts;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_LOWA + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ design/ifmt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ifmt_ctrl
// Sequencer: accept a word, run the digit loop, then stream the characters.
// ----------------------------------------------------------------------------
module ifmt_ctrl
    import ifmt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIG  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIG;
            end
            S_DIG: begin
                o_cmd.dig = 1'b1;
                n_state   = i_sts.dig_done ? S_EMIT : S_MUL;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_load_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_MUL)
        else $error("load did not start the digit loop");
    a_done_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG && i_sts.dig_done) |=> r_state == S_EMIT)
        else $error("digit loop end did not start emission");
`endif

endmodule
`default_nettype wire

@@ design/ifmt_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ifmt_dp
// Datapath: magnitude register, divide-by-ten step, digit buffer, character
// select and output register.
// ----------------------------------------------------------------------------
module ifmt_dp
    import ifmt_pkg::*;
#(
    parameter int MAX_WIDTH = 31
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [31:0] i_value,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [4:0]  i_pad_width,
    output t_sts             o_sts,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_char_code,
    output logic             o_last_char
);

    localparam int CW = $clog2(MAX_WIDTH + 1);

    t_kind                r_kind;
    logic                 r_neg;
    logic [CW-1:0]        r_width;
    logic [31:0]          r_mag;
    logic [63:0]          r_prod;
    logic [3:0]           r_dig [MAX_DIGITS];
    logic [DIG_IW:0]      r_nd;
    logic [CW-1:0]        r_pos;
    logic                 r_out_valid;
    logic [7:0]           r_char;
    logic                 r_last;

    logic [6:0]           pad7;
    logic [6:0]           width7;
    logic [28:0]          quot;
    logic [3:0]           q10_lo;
    logic [3:0]           digit;
    logic [31:0]          n_mag;
    logic [CW-1:0]        nd_ext;
    logic [CW-1:0]        len;
    logic [CW-1:0]        total;
    logic [CW-1:0]        idx;
    logic                 is_sign;
    logic                 is_pad;
    logic [7:0]           ch;

    // Saturate the requested width.
    always_comb begin
        pad7   = {2'b00, i_pad_width};
        width7 = (pad7 > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : pad7;
    end

    // One digit per step, least significant first.
    always_comb begin
        quot   = r_prod[63:RECIP_SHIFT];
        q10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
        unique case (r_kind)
            KIND_SDEC, KIND_UDEC: begin
                digit = r_mag[3:0] - q10_lo;
                n_mag = {3'b000, quot};
            end
            KIND_HEX: begin
                digit = r_mag[3:0];
                n_mag = {4'h0, r_mag[31:4]};
            end
            default: begin
                digit = {1'b0, r_mag[2:0]};
                n_mag = {3'b000, r_mag[31:3]};
            end
        endcase
    end

    // Character at the current output position: sign, pad zeros, digits.
    always_comb begin
        nd_ext  = CW'(r_nd);
        len     = nd_ext + CW'(r_neg);
        total   = (r_width > len) ? r_width : len;
        idx     = total - CW'(1) - r_pos;
        is_sign = r_neg && (r_pos == '0);
        is_pad  = !is_sign && (r_pos < (total - nd_ext));
        if (is_sign) begin
            ch = CHAR_MINUS;
        end else if (is_pad) begin
            ch = CHAR_ZERO;
        end else begin
            ch = digit_char(r_dig[idx[DIG_IW-1:0]]);
        end
    end

    assign o_sts.dig_done = (n_mag == 32'd0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.last     = (r_pos == total - CW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= t_kind'(i_req_type);
            r_width <= CW'(width7);
            if (t_kind'(i_req_type) == KIND_SDEC && i_value[31]) begin
                r_neg <= 1'b1;
                r_mag <= 32'd0 - i_value;
            end else begin
                r_neg <= 1'b0;
                r_mag <= i_value;
            end
        end else if (i_cmd.dig) begin
            r_mag <= n_mag;
        end
        if (i_cmd.mul) begin
            r_prod <= r_mag * RECIP_10;
        end
        if (i_cmd.dig) begin
            r_dig[r_nd[DIG_IW-1:0]] <= digit;
        end
        if (i_cmd.emit) begin
            r_char <= ch;
            r_last <= o_sts.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd        <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_nd  <= '0;
                r_pos <= '0;
            end else begin
                if (i_cmd.dig) begin
                    r_nd <= r_nd + 1'b1;
                end
                if (i_cmd.emit) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

`ifndef ASSERT_OFF
    a_nd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nd <= (DIG_IW + 1)'(MAX_DIGITS))
        else $error("digit buffer overrun");
    a_dig_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !is_sign && !is_pad) |-> idx < nd_ext)
        else $error("digit read beyond stored digits");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !i_cmd.emit)
        else $error("output word overwritten while stalled");
`endif

endmodule
`default_nettype wire

@@ design/integer_to_ascii_formatter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Converts a 32-bit value to ASCII text, one character per output word.
// ----------------------------------------------------------------------------
// One word is taken at a time. After it is accepted the digit loop handles each
// digit with a 32x32 reciprocal multiply by 1/10 and then the digit extract;
// hex and octal go through the same multiply and extract steps, for up to 11
// digits of an octal value. Characters then leave one per cycle through the
// output register while the output is not stalled, max(pad width, text length)
// of them, at most 31 (the text alone is at most 11). The next word is accepted
// as soon as the last character is loaded into the output register.
module integer_to_ascii_formatter
    import ifmt_pkg::*;
#(
    parameter int MAX_WIDTH = 31
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [31:0] value, [36:32] pad_width
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [7:0] char_code
    output logic             m_axis_tlast
);

    t_cmd cmd;
    t_sts sts;

    ifmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ifmt_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (s_axis_tdata[31:0]),
        .i_req_type  (s_axis_tuser),
        .i_pad_width (s_axis_tdata[36:32]),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_char_code (m_axis_tdata),
        .o_last_char (m_axis_tlast)
    );

endmodule
`default_nettype wire
